/* sv/handle_flag_store_top_defines.svh */
// Assertion macros for the handle flag store.
// Used by handle_flag_store_top.sv; needs signals clock and reset in scope.
`ifndef HANDLE_FLAG_STORE_TOP_DEFINES_SVH
`define HANDLE_FLAG_STORE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HFS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HFS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/hfs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the handle flag store.
// No dependencies; imported by every module of the block.
package hfs_pkg;

   localparam int HFS_KIND_BITS       = 3;
   localparam int HFS_HANDLE_FIELD    = 8;
   localparam int HFS_HANDLE_BITS_DEF = 8;

   localparam logic [HFS_KIND_BITS-1:0] KIND_ALLOC  = 3'd0;
   localparam logic [HFS_KIND_BITS-1:0] KIND_FREE   = 3'd1;
   localparam logic [HFS_KIND_BITS-1:0] KIND_SET    = 3'd2;
   localparam logic [HFS_KIND_BITS-1:0] KIND_CLEAR  = 3'd3;
   localparam logic [HFS_KIND_BITS-1:0] KIND_TOGGLE = 3'd4;
   localparam logic [HFS_KIND_BITS-1:0] KIND_WRITE  = 3'd5;
   localparam logic [HFS_KIND_BITS-1:0] KIND_TEST   = 3'd6;

   typedef struct packed {
      logic [HFS_KIND_BITS-1:0]    kind;
      logic [HFS_HANDLE_FIELD-1:0] handle;
      logic                        value;
   } hfs_req_type;

   typedef struct packed {
      logic [HFS_HANDLE_FIELD-1:0] handle_out;
      logic                        flag;
      logic                        error;
   } hfs_rsp_type;

   // Free list status, valid in the cycle an item is accepted.
   typedef struct packed {
      logic has_free;   // stack not empty
      logic has_fresh;  // fresh handles left
      logic full;       // stack holds every handle
   } hfs_list_stat_type;

endpackage

/* sv/handle_flag_store_top.sv */
`timescale 1ns / 1ps
// Handle flag store top level: free list, flag RAM, two-stage pipeline.
// Depends on hfs_pkg, hfs_free_list, hfs_flag_bank, handle_flag_store_top_defines.svh.
//
//   channel | dir | payload      | handshake
//   --------+-----+--------------+-------------------------
//   req     | in  | hfs_req_type | req_valid / req_ready
//   rsp     | out | hfs_rsp_type | rsp_valid / rsp_ready
//
// One beat per cycle sustained while rsp_ready stays high and no sweep runs;
// the flag RAM is read at accept, read-modify-write happens in stage 1, and the
// result register drives rsp_valid.
// After reset the flag RAM is swept to zero with req_ready low.
// rsp_ready low holds stage 1 and the result register; two beats buffered.
module handle_flag_store_top #(
   parameter int HANDLE_BITS = hfs_pkg::HFS_HANDLE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hfs_pkg::hfs_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hfs_pkg::hfs_rsp_type rsp_payload
);
   import hfs_pkg::*;

`include "handle_flag_store_top_defines.svh"

   // accept side
   logic                     req_fire;
   logic [HANDLE_BITS-1:0]   req_handle;
   logic                     is_alloc, is_free;
   logic                     do_pop, do_push, do_fresh;
   hfs_list_stat_type        list_stat;
   logic [HANDLE_BITS-1:0]   pop_handle, fresh_handle;
   logic                     flag_busy, flag_rd;
   logic                     s1_cur_raw;

   // stage 1 (item register + RAM read data)
   logic                     s1_valid_ff, s1_valid_in;
   logic [HFS_KIND_BITS-1:0] s1_kind_ff;
   logic [HANDLE_BITS-1:0]   s1_handle_ff, s1_handle_in;
   logic                     s1_value_ff;
   logic                     s1_stack_ff;   // handle comes from the stack read
   logic                     s1_err_ff, s1_err_in;
   logic                     s1_fwd_ff, s1_fwd_in;
   logic                     s1_fwd_data_ff;
   logic                     s1_adv;
   logic [HANDLE_BITS-1:0]   s1_handle;
   logic                     s1_cur, s1_new, s1_wr;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   hfs_rsp_type              rsp_payload_ff, rsp_payload_in;

   // ---------------- accept ----------------
   assign req_handle = HANDLE_BITS'(req_payload.handle);   // mask / extend
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !flag_busy && (!s1_valid_ff || s1_adv);
   assign req_fire   = req_valid && req_ready;

   assign is_alloc = (req_payload.kind == KIND_ALLOC);
   assign is_free  = (req_payload.kind == KIND_FREE);
   assign do_pop   = req_fire && is_alloc && list_stat.has_free;
   assign do_fresh = req_fire && is_alloc && !list_stat.has_free && list_stat.has_fresh;
   assign do_push  = req_fire && is_free && !list_stat.full;

   // only toggle, test and no-op need the old bit, but reading always is harmless
   assign flag_rd = req_fire;

   assign s1_handle_in = do_fresh ? fresh_handle : req_handle;
   assign s1_err_in    = (is_alloc && !list_stat.has_free && !list_stat.has_fresh)
                       || (is_free && list_stat.full);

   // a stage-1 write landing on the same edge as this read is not seen by
   // the RAM read, so carry it along
   assign s1_fwd_in = s1_adv && s1_wr && (s1_handle == req_handle);

   hfs_free_list #(
      .HANDLE_BITS(HANDLE_BITS)
   ) u_free_list (
      .clock       (clock),
      .reset       (reset),
      .push        (do_push),
      .push_handle (req_handle),
      .pop         (do_pop),
      .take_fresh  (do_fresh),
      .pop_handle  (pop_handle),
      .fresh_handle(fresh_handle),
      .stat        (list_stat)
   );

   hfs_flag_bank #(
      .HANDLE_BITS(HANDLE_BITS)
   ) u_flag_bank (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (flag_rd),
      .rd_addr(req_handle),
      .rd_data(s1_cur_raw),
      .wr_en  (s1_adv && s1_wr),
      .wr_addr(s1_handle),
      .wr_data(s1_new),
      .busy   (flag_busy)
   );

   // ---------------- stage 1 ----------------
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff     <= req_payload.kind;
         s1_handle_ff   <= s1_handle_in;
         s1_value_ff    <= req_payload.value;
         s1_stack_ff    <= do_pop;
         s1_err_ff      <= s1_err_in;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_data_ff <= s1_new;
      end
   end

   assign s1_handle = s1_stack_ff ? pop_handle : s1_handle_ff;
   assign s1_cur    = s1_fwd_ff ? s1_fwd_data_ff : s1_cur_raw;

   always_comb begin
      s1_new = s1_cur;
      s1_wr  = 1'b1;
      case (s1_kind_ff) inside
         KIND_ALLOC: begin
            s1_new = 1'b0;
            s1_wr  = !s1_err_ff;   // exhausted allocate leaves the store alone
         end
         KIND_FREE, KIND_CLEAR: s1_new = 1'b0;
         KIND_SET:              s1_new = 1'b1;
         KIND_TOGGLE:           s1_new = !s1_cur;
         KIND_WRITE:            s1_new = s1_value_ff;
         default:               s1_wr  = 1'b0;   // test and unused code
      endcase
   end

   always_comb begin
      rsp_payload_in.handle_out = HFS_HANDLE_FIELD'(s1_handle);
      rsp_payload_in.flag       = s1_new;
      rsp_payload_in.error      = s1_err_ff;
      if (s1_kind_ff == KIND_ALLOC && s1_err_ff) begin
         rsp_payload_in.handle_out = '0;
         rsp_payload_in.flag       = 1'b0;
      end
   end

   // ---------------- result register ----------------
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------- checks ----------------
   `HFS_ASSERT_NOW(a_sweep_idle, flag_busy, !s1_valid_ff && !rsp_valid_ff && !req_ready, "item in flight during flag sweep")
   `HFS_ASSERT_NOW(a_err_kind, s1_valid_ff && s1_err_ff, s1_kind_ff == KIND_ALLOC || s1_kind_ff == KIND_FREE, "error raised by a kind that cannot fail")
   `HFS_ASSERT_NEXT(a_alloc_zero, s1_adv && s1_kind_ff == KIND_ALLOC, rsp_valid && !rsp_payload.flag, "allocate returned a set flag")
   `HFS_ASSERT_NOW(a_one_list_op, 1'b1, !(do_pop && do_push) && !(do_pop && do_fresh), "two free list operations in one beat")

endmodule

/* sv/hfs_free_list.sv */
`timescale 1ns / 1ps
// Free handle LIFO plus fresh handle counter.
// Depends on hfs_pkg.
module hfs_free_list #(
   parameter int HANDLE_BITS = hfs_pkg::HFS_HANDLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [HANDLE_BITS-1:0]    push_handle,
   input  logic                      pop,
   input  logic                      take_fresh,
   output logic [HANDLE_BITS-1:0]    pop_handle,
   output logic [HANDLE_BITS-1:0]    fresh_handle,
   output hfs_pkg::hfs_list_stat_type stat
);
   import hfs_pkg::*;

   localparam int DEPTH = 1 << HANDLE_BITS;

   logic [HANDLE_BITS-1:0] stack_ff [DEPTH];
   logic [HANDLE_BITS-1:0] pop_handle_ff;
   logic [HANDLE_BITS:0]   count_ff, count_in, count_dec;
   logic [HANDLE_BITS-1:0] fresh_ff, fresh_in;

   assign count_dec = count_ff - (HANDLE_BITS+1)'(1);
   assign count_in  = count_ff + (HANDLE_BITS+1)'(push) - (HANDLE_BITS+1)'(pop);
   assign fresh_in  = fresh_ff + HANDLE_BITS'(take_fresh);

   assign stat.has_free  = (count_ff != '0);
   assign stat.has_fresh = (fresh_ff != '1);
   assign stat.full      = count_ff[HANDLE_BITS];

   assign pop_handle   = pop_handle_ff;
   assign fresh_handle = fresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fresh_ff <= '0;
      end else begin
         count_ff <= count_in;
         fresh_ff <= fresh_in;
      end
   end

   // push and pop never come from the same beat
   always_ff @(posedge clock) begin
      if (push) begin
         stack_ff[count_ff[HANDLE_BITS-1:0]] <= push_handle;
      end
      if (pop) begin
         pop_handle_ff <= stack_ff[count_dec[HANDLE_BITS-1:0]];
      end
   end

endmodule

/* sv/hfs_flag_bank.sv */
`timescale 1ns / 1ps
// Flag bit RAM with a clearing sweep after reset.
// Depends on hfs_pkg for the default width.
module hfs_flag_bank #(
   parameter int HANDLE_BITS = hfs_pkg::HFS_HANDLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [HANDLE_BITS-1:0] rd_addr,
   output logic                   rd_data,
   input  logic                   wr_en,
   input  logic [HANDLE_BITS-1:0] wr_addr,
   input  logic                   wr_data,
   output logic                   busy
);
   import hfs_pkg::*;

   localparam int DEPTH = 1 << HANDLE_BITS;

   logic                   flag_mem_ff [DEPTH];
   logic                   rd_data_ff;
   logic                   busy_ff;
   logic [HANDLE_BITS-1:0] clr_addr_ff;

   assign busy    = busy_ff;
   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else if (busy_ff) begin
         clr_addr_ff <= clr_addr_ff + HANDLE_BITS'(1);
         if (clr_addr_ff == '1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // read returns the value before a same-edge write
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         flag_mem_ff[clr_addr_ff] <= 1'b0;
      end else if (wr_en) begin
         flag_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= flag_mem_ff[rd_addr];
      end
   end

endmodule
